>>> sv/sbfd_pkg.sv
// SBUS frame decoder package: frame record, queue status and scaling constants.
// Used by every module of the decoder; depends on nothing.
`timescale 1ns / 1ps

package sbfd_pkg;

   localparam int FRAME_BYTES = 25;
   localparam int ANALOG_CHANNELS = 16;
   localparam int CODE_BITS = 11;
   localparam int CHAN_BITS = ANALOG_CHANNELS * CODE_BITS;
   localparam int FLAG_BYTE = 23;

   localparam logic [7:0] HEADER_BYTE = 8'h0F;
   localparam logic [7:0] FOOTER_BYTE = 8'h00;

   localparam logic [CODE_BITS-1:0] CODE_LOW = 11'd172;
   localparam logic [CODE_BITS-1:0] CODE_HIGH = 11'd1811;
   localparam logic [9:0] HALF_SPAN = 10'd819;

   localparam int SCALE_SHIFT = 36;
   localparam logic [25:0] SCALE_MUL = 26'(((64'd1 << SCALE_SHIFT) + 64'd1638) / 64'd1639);

   localparam int NUM_BITS = CODE_BITS + 14;
   localparam int PROD_BITS = NUM_BITS + 26;
   localparam int MAG_BITS = 15;

   typedef struct packed {
      logic [7:0]           flags;
      logic [CHAN_BITS-1:0] chan_bits;
   } sbfd_frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sbfd_q_status_type;

endpackage

>>> sv/sbfd_front.sv
// SBUS decoder front end: collects frame bytes, checks header and footer, pushes good frames.
// Depends on sbfd_pkg.
`timescale 1ns / 1ps

module sbfd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   input  logic                      req_starts_frame,
   input  sbfd_pkg::sbfd_q_status_type q_status,
   output logic                      q_push,
   output sbfd_pkg::sbfd_frame_type  q_data
);
   import sbfd_pkg::*;

   logic [7:0] store_ff [FRAME_BYTES];
   logic [4:0] pos_ff;
   logic [4:0] pos_in;
   logic       accept;
   logic       in_frame;

   assign req_ready = !q_status.full;
   assign accept = req_valid && req_ready;
   assign in_frame = pos_ff < 5'(FRAME_BYTES);

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_starts_frame) begin
            pos_in = 5'd1;
         end else if (in_frame) begin
            pos_in = pos_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 5'(FRAME_BYTES);
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (req_starts_frame) begin
            store_ff[0] <= req_rx_byte;
         end else if (in_frame) begin
            store_ff[pos_ff] <= req_rx_byte;
         end
      end
   end

   always_comb begin
      q_data.flags = store_ff[FLAG_BYTE];
      for (int i = 0; i < CHAN_BITS / 8; i++) begin
         q_data.chan_bits[8*i +: 8] = store_ff[i+1];
      end
   end

   assign q_push = accept && !req_starts_frame && (pos_ff == 5'(FRAME_BYTES - 1))
                   && (store_ff[0] == HEADER_BYTE) && (req_rx_byte == FOOTER_BYTE);

endmodule

>>> sv/sbfd_fifo.sv
// Two-entry frame queue between front and back end of the SBUS decoder.
// Depends on sbfd_pkg.
`timescale 1ns / 1ps

module sbfd_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sbfd_pkg::sbfd_frame_type   push_data,
   input  logic                       pop,
   output sbfd_pkg::sbfd_frame_type   head,
   output sbfd_pkg::sbfd_q_status_type status
);
   import sbfd_pkg::*;

   sbfd_frame_type mem_ff [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic       do_push;
   logic       do_pop;

   assign status.full = count_ff == 2'd2;
   assign status.empty = count_ff == 2'd0;
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;
   assign head = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/sbfd_back.sv
// SBUS decoder back end: walks the channels of a queued frame and scales each code.
// Depends on sbfd_pkg.
`timescale 1ns / 1ps

module sbfd_back #(
   parameter int OUTPUT_CHANNELS = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sbfd_pkg::sbfd_frame_type    head,
   input  sbfd_pkg::sbfd_q_status_type q_status,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [4:0]                  rsp_channel_index,
   output logic signed [15:0]          rsp_channel_value,
   output logic                        rsp_frame_lost,
   output logic                        rsp_failsafe_active,
   output logic                        rsp_link_good,
   output logic                        rsp_last_channel
);
   import sbfd_pkg::*;

   logic [4:0] ch_ff;
   logic [4:0] ch_in;
   logic       advance;
   logic       issue;
   logic       is_last;

   logic [CODE_BITS-1:0] code;
   logic [CODE_BITS:0]   diff;
   logic                 neg;
   logic [CODE_BITS-1:0] mag;

   logic                 s1_valid_ff;
   logic [NUM_BITS-1:0]  s1_num_ff;
   logic                 s1_neg_ff;
   logic [4:0]           s1_ch_ff;
   logic                 s1_lost_ff;
   logic                 s1_fs_ff;
   logic                 s1_last_ff;

   logic                 s2_valid_ff;
   logic [PROD_BITS-1:0] s2_prod_ff;
   logic                 s2_neg_ff;
   logic [4:0]           s2_ch_ff;
   logic                 s2_lost_ff;
   logic                 s2_fs_ff;
   logic                 s2_last_ff;

   logic [MAG_BITS-1:0]  quot;
   logic [15:0]          value;
   logic                 out_valid_ff;

   assign advance = !out_valid_ff || rsp_ready;
   assign issue = advance && !q_status.empty;
   assign is_last = ch_ff == 5'(OUTPUT_CHANNELS - 1);
   assign q_pop = issue && is_last;

   always_comb begin
      ch_in = ch_ff;
      if (issue) begin
         ch_in = is_last ? 5'd0 : ch_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff <= 5'd0;
      end else begin
         ch_ff <= ch_in;
      end
   end

   always_comb begin
      if (ch_ff < 5'(ANALOG_CHANNELS)) begin
         code = head.chan_bits[CODE_BITS*ch_ff[3:0] +: CODE_BITS];
      end else begin
         code = head.flags[ch_ff[2:0]] ? CODE_LOW : CODE_HIGH;
      end
      diff = {1'b0, code} - {1'b0, CODE_LOW};
      neg = diff[CODE_BITS];
      mag = neg ? CODE_BITS'(-diff) : diff[CODE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   assign quot = s2_prod_ff[SCALE_SHIFT +: MAG_BITS];
   assign value = s2_neg_ff ? -{1'b0, quot} : {1'b0, quot};

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_num_ff <= {mag, 14'd0} + NUM_BITS'(HALF_SPAN);
         s1_neg_ff <= neg;
         s1_ch_ff <= ch_ff;
         s1_lost_ff <= head.flags[2];
         s1_fs_ff <= head.flags[3];
         s1_last_ff <= is_last;

         s2_prod_ff <= PROD_BITS'(s1_num_ff) * PROD_BITS'(SCALE_MUL);
         s2_neg_ff <= s1_neg_ff;
         s2_ch_ff <= s1_ch_ff;
         s2_lost_ff <= s1_lost_ff;
         s2_fs_ff <= s1_fs_ff;
         s2_last_ff <= s1_last_ff;

         rsp_channel_index <= s2_ch_ff;
         rsp_channel_value <= value;
         rsp_frame_lost <= s2_lost_ff;
         rsp_failsafe_active <= s2_fs_ff;
         rsp_link_good <= !(s2_lost_ff || s2_fs_ff);
         rsp_last_channel <= s2_last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

>>> sv/sbus_frame_decoder_top.sv
// SBUS frame decoder top: one received byte per cycle in, channel words out.
// Footer queues the frame; words pass s1, s2 and output, one per cycle while rsp_ready is high.
// Throughput: one byte per cycle; each good frame gives OUTPUT_CHANNELS words.
// The byte side stalls only while both entries of the two-frame queue are taken.
// Synchronous reset: frame position waits for a frame start, queue and pipeline empty.
`timescale 1ns / 1ps

module sbus_frame_decoder_top #(
   parameter int OUTPUT_CHANNELS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_starts_frame,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [4:0]         rsp_channel_index,
   output logic signed [15:0] rsp_channel_value,
   output logic               rsp_frame_lost,
   output logic               rsp_failsafe_active,
   output logic               rsp_link_good,
   output logic               rsp_last_channel
);
   import sbfd_pkg::*;

   sbfd_q_status_type q_status;
   sbfd_frame_type    push_data;
   sbfd_frame_type    head;
   logic              q_push;
   logic              q_pop;

   sbfd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .req_starts_frame (req_starts_frame),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_data           (push_data)
   );

   sbfd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .head      (head),
      .status    (q_status)
   );

   sbfd_back #(
      .OUTPUT_CHANNELS (OUTPUT_CHANNELS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .q_status            (q_status),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_frame_lost      (rsp_frame_lost),
      .rsp_failsafe_active (rsp_failsafe_active),
      .rsp_link_good       (rsp_link_good),
      .rsp_last_channel    (rsp_last_channel)
   );

endmodule

>>> sv/sbfd_checker.sv
// Port-level checks for the SBUS frame decoder, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module sbfd_checker #(
   parameter int OUTPUT_CHANNELS = 24
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [4:0]         rsp_channel_index,
   input logic signed [15:0] rsp_channel_value,
   input logic               rsp_frame_lost,
   input logic               rsp_failsafe_active,
   input logic               rsp_link_good,
   input logic               rsp_last_channel
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_channel_index)
                                  && $stable(rsp_channel_value))
      else $error("result word changed while stalled");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_channel == (rsp_channel_index == 5'(OUTPUT_CHANNELS - 1)))
      else $error("last flag does not match final channel");

   a_link_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_link_good == !(rsp_frame_lost || rsp_failsafe_active))
      else $error("link good inconsistent with flags");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_channel_index < 5'(OUTPUT_CHANNELS))
      else $error("channel index out of range");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_channel_value >= -16'sd1720 && rsp_channel_value <= 16'sd18744)
      else $error("channel value out of range");

endmodule

bind sbus_frame_decoder_top sbfd_checker #(.OUTPUT_CHANNELS(OUTPUT_CHANNELS)) u_checker (.*);

>>> bench/tb_top.sv
// Self-checking bench for sbus_frame_decoder_top: sends SBUS byte streams, predicts every
// channel word in a small scoreboard class and compares them as the block emits them.
// Depends on sbfd_pkg and sbus_frame_decoder_top.
`timescale 1ns / 1ps

module tb_top;
   import sbfd_pkg::*;

   localparam int NUM_CHANNELS = 24;
   localparam int CODE_SPAN = 1639;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [4:0]         index;
      logic signed [15:0] value;
      logic               lost;
      logic               failsafe;
      logic               good;
      logic               last;
   } channel_word_type;

   class scoreboard_type;
      logic [7:0]       frame_store [FRAME_BYTES];
      int unsigned      position;
      channel_word_type expected_words [$];
      int               mismatches;

      function new();
         position = FRAME_BYTES;
         mismatches = 0;
      endfunction

      function logic signed [15:0] scaled_value(input int code);
         int n;
         n = (code - int'(CODE_LOW)) * 16384;
         if (n >= 0) begin
            return 16'((n + CODE_SPAN / 2) / CODE_SPAN);
         end
         return 16'(-((-n + CODE_SPAN / 2) / CODE_SPAN));
      endfunction

      function void note_byte(input logic [7:0] rx_byte, input logic starts_frame);
         logic [CHAN_BITS-1:0] chan_bits;
         logic [7:0]           flags;
         channel_word_type     w;
         int                   code;
         if (starts_frame) begin
            frame_store[0] = rx_byte;
            position = 1;
            return;
         end
         if (position >= FRAME_BYTES) return;
         frame_store[position] = rx_byte;
         position++;
         if (position < FRAME_BYTES) return;
         if (frame_store[0] != HEADER_BYTE || frame_store[FRAME_BYTES-1] != FOOTER_BYTE) return;
         for (int j = 1; j <= CHAN_BITS / 8; j++) begin
            chan_bits[8*(j-1) +: 8] = frame_store[j];
         end
         flags = frame_store[FLAG_BYTE];
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (ch < ANALOG_CHANNELS) begin
               code = int'(chan_bits[CODE_BITS*ch +: CODE_BITS]);
            end else begin
               code = flags[ch-ANALOG_CHANNELS] ? int'(CODE_LOW) : int'(CODE_HIGH);
            end
            w.index = 5'(ch);
            w.value = scaled_value(code);
            w.lost = flags[2];
            w.failsafe = flags[3];
            w.good = !(flags[2] || flags[3]);
            w.last = (ch == NUM_CHANNELS - 1);
            expected_words.push_back(w);
         end
      endfunction

      function void check_word(input channel_word_type got);
         channel_word_type exp;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected channel word: index %0d value %0d", got.index, got.value);
            end
            return;
         end
         exp = expected_words.pop_front();
         if (got.index !== exp.index || got.value !== exp.value || got.lost !== exp.lost ||
             got.failsafe !== exp.failsafe || got.good !== exp.good || got.last !== exp.last)
         begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("channel word mismatch: expected idx %0d val %0d lost %b fs %b good %b last %b",
                        exp.index, exp.value, exp.lost, exp.failsafe, exp.good, exp.last);
               $display("                       actual   idx %0d val %0d lost %b fs %b good %b last %b",
                        got.index, got.value, got.lost, got.failsafe, got.good, got.last);
            end
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               req_starts_frame = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [4:0]         rsp_channel_index;
   logic signed [15:0] rsp_channel_value;
   logic               rsp_frame_lost;
   logic               rsp_failsafe_active;
   logic               rsp_link_good;
   logic               rsp_last_channel;

   int                 cycles = 0;
   int unsigned        send_idle = 0;
   int unsigned        rsp_stall = 0;
   logic               hold_req = 1'b0;
   logic               hold_seen = 1'b0;
   int                 hold_left = 0;
   logic [7:0]         frame_buf [FRAME_BYTES];

   scoreboard_type sb = new();

   sbus_frame_decoder_top uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .req_starts_frame    (req_starts_frame),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_channel_index   (rsp_channel_index),
      .rsp_channel_value   (rsp_channel_value),
      .rsp_frame_lost      (rsp_frame_lost),
      .rsp_failsafe_active (rsp_failsafe_active),
      .rsp_link_good       (rsp_link_good),
      .rsp_last_channel    (rsp_last_channel)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_byte(req_rx_byte, req_starts_frame);
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_seen <= hold_req;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_word({rsp_channel_index, rsp_channel_value, rsp_frame_lost,
                           rsp_failsafe_active, rsp_link_good, rsp_last_channel});
         end
         if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall);
         end
      end
   end

   task automatic send_byte(input logic [7:0] rx_byte, input logic starts_frame);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= rx_byte;
      req_starts_frame <= starts_frame;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_frame(input int n_bytes);
      for (int i = 0; i < n_bytes; i++) begin
         send_byte(frame_buf[i], i == 0);
      end
   endtask

   function automatic void make_frame(input bit random_fill, input logic [7:0] fill,
                                      input logic [7:0] flags);
      frame_buf[0] = HEADER_BYTE;
      for (int i = 1; i < FLAG_BYTE; i++) begin
         frame_buf[i] = random_fill ? 8'($urandom_range(255)) : fill;
      end
      frame_buf[FLAG_BYTE] = flags;
      frame_buf[FRAME_BYTES-1] = FOOTER_BYTE;
   endfunction

   task automatic send_trailing(input int count);
      for (int i = 0; i < count; i++) begin
         send_byte(8'($urandom_range(255)), 1'b0);
      end
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // drop bytes while waiting for a frame start
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
      // hold the receiver off: two good frames fill the queue, the bad header stalls
      hold_req <= ~hold_req;
      make_frame(1'b0, 8'hFF, 8'hFF);
      send_frame(FRAME_BYTES);
      make_frame(1'b0, 8'h00, 8'h04);
      send_frame(FRAME_BYTES);
      make_frame(1'b1, 8'h00, 8'h00);
      frame_buf[0] = 8'h0E;
      send_frame(FRAME_BYTES);

      // sender idling; restart on a new frame start mid-frame
      send_idle = 59;
      make_frame(1'b1, 8'h00, 8'h08);
      send_frame(3);
      send_frame(FRAME_BYTES);

      // receiver stalling; bad footer
      send_idle = 0;
      rsp_stall = 59;
      make_frame(1'b1, 8'h00, 8'h00);
      frame_buf[FRAME_BYTES-1] = 8'($urandom_range(1, 255));
      send_frame(FRAME_BYTES);

      // both idling; drop bytes past the footer
      send_idle = 37;
      rsp_stall = 37;
      make_frame(1'b1, 8'h00, 8'($urandom_range(255)));
      send_frame(FRAME_BYTES);
      send_trailing(2);
      req_valid <= 1'b0;
      drain();

      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> sbus_frame_decoder_top.f
sv/sbfd_pkg.sv
sv/sbfd_front.sv
sv/sbfd_fifo.sv
sv/sbfd_back.sv
sv/sbus_frame_decoder_top.sv
sv/sbfd_checker.sv
bench/tb_top.sv
